>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

>>> rtl/core/hpfg_pkg.sv
// types and constants of the hold press filter
package hpfg_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned MS_W = 16;
	localparam int unsigned POS_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// register reset values
	localparam logic [MS_W-1:0] LOSS_GRACE_RST = 16'd200;
	localparam logic [MS_W-1:0] HOLD_BIAS_RST = 16'd150;
	localparam logic [MS_W-1:0] PRESS_DEBOUNCE_RST = 16'd30;
	localparam logic BIAS_ENABLE_RST = 1'b0;
	// about 0.022 of the full range in q0.16
	localparam logic [POS_W-1:0] NEAR_THRESHOLD_RST = 16'd1442;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOSS_GRACE     = 3'd0,
		CFG_HOLD_BIAS      = 3'd1,
		CFG_PRESS_DEBOUNCE = 3'd2,
		CFG_BIAS_ENABLE    = 3'd3,
		CFG_NEAR_THRESHOLD = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [MS_W-1:0]  loss_grace_ms;
		logic [MS_W-1:0]  hold_bias_ms;
		logic [MS_W-1:0]  press_debounce_ms;
		logic             bias_enable;
		logic [POS_W-1:0] near_threshold;
	} cfg_t;

	typedef struct packed {
		logic              metrics_valid;
		logic              hold_request;
		logic [TIME_W-1:0] now_ms;
		logic              tracking_mode;
		logic [POS_W-1:0]  target_pos;
		logic [POS_W-1:0]  bar_pos;
	} item_t;

	typedef struct packed {
		logic              holding;
		logic              last_request;
		logic [TIME_W-1:0] request_changed_at;
		logic [TIME_W-1:0] last_seen_at;
		logic [TIME_W-1:0] bias_until;
	} state_t;

	localparam state_t STATE_RST = '0;

endpackage

>>> rtl/core/hpfg_cfg_regs.sv
// configuration register file
module hpfg_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hpfg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hpfg_pkg::CFG_DATA_W-1:0]   cfg_data,
	output hpfg_pkg::cfg_t                    cfg
);
	import hpfg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loss_grace_ms <= LOSS_GRACE_RST;
			cfg_q.hold_bias_ms <= HOLD_BIAS_RST;
			cfg_q.press_debounce_ms <= PRESS_DEBOUNCE_RST;
			cfg_q.bias_enable <= BIAS_ENABLE_RST;
			cfg_q.near_threshold <= NEAR_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LOSS_GRACE:     cfg_q.loss_grace_ms <= cfg_data[MS_W-1:0];
				CFG_HOLD_BIAS:      cfg_q.hold_bias_ms <= cfg_data[MS_W-1:0];
				CFG_PRESS_DEBOUNCE: cfg_q.press_debounce_ms <= cfg_data[MS_W-1:0];
				CFG_BIAS_ENABLE:    cfg_q.bias_enable <= cfg_data[0];
				CFG_NEAR_THRESHOLD: cfg_q.near_threshold <= cfg_data[POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/hpfg_step.sv
// next-state and output logic for one request
module hpfg_step (
	input  hpfg_pkg::item_t  item,
	input  hpfg_pkg::state_t st,
	input  hpfg_pkg::cfg_t   cfg,
	output hpfg_pkg::state_t st_next,
	output logic             hold
);
	import hpfg_pkg::*;

	logic [TIME_W:0]   since_seen;
	logic              in_grace;
	logic [TIME_W:0]   bias_sum;
	logic [TIME_W-1:0] bias_deadline;
	logic [POS_W-1:0]  pos_diff;
	logic              want;
	logic [TIME_W:0]   elapsed;
	logic              debounce_pending;
	logic              debounced;

	always_comb begin
		// signed time differences via a 33-bit subtract
		since_seen = {1'b0, item.now_ms} - {1'b0, st.last_seen_at};
		in_grace = (st.last_seen_at != '0) &&
			(since_seen[TIME_W] ||
			 (since_seen[TIME_W-1:0] <= {{(TIME_W-MS_W){1'b0}}, cfg.loss_grace_ms}));

		bias_sum = {1'b0, item.now_ms} + {{(TIME_W-MS_W+1){1'b0}}, cfg.hold_bias_ms};
		bias_deadline = bias_sum[TIME_W] ? '1 : bias_sum[TIME_W-1:0];

		pos_diff = (item.target_pos >= item.bar_pos) ? item.target_pos - item.bar_pos
			: item.bar_pos - item.target_pos;

		want = item.hold_request;
		if ((item.tracking_mode || cfg.bias_enable) && !item.hold_request) begin
			want = st.holding && (item.now_ms < st.bias_until) &&
				(pos_diff <= cfg.near_threshold);
		end

		elapsed = {1'b0, item.now_ms} - {1'b0, st.request_changed_at};
		debounce_pending = elapsed[TIME_W] ||
			(elapsed[TIME_W-1:0] < {{(TIME_W-MS_W){1'b0}}, cfg.press_debounce_ms});

		if (want != st.last_request) begin
			debounced = st.holding;
		end else if (want == st.holding) begin
			debounced = want;
		end else if (!want) begin
			debounced = 1'b0;
		end else begin
			debounced = debounce_pending ? st.holding : 1'b1;
		end

		st_next = st;
		if (!item.metrics_valid) begin
			// grace expired: drop everything
			if (!in_grace) begin
				st_next = STATE_RST;
			end
		end else begin
			st_next.last_seen_at = item.now_ms;
			if ((item.tracking_mode || cfg.bias_enable) && item.hold_request) begin
				st_next.bias_until = bias_deadline;
			end
			if (item.tracking_mode) begin
				st_next.holding = want;
			end else begin
				st_next.holding = debounced;
				if (want != st.last_request) begin
					st_next.last_request = want;
					st_next.request_changed_at = item.now_ms;
				end
			end
		end
		hold = st_next.holding;
	end

endmodule

>>> rtl/core/hold_press_filter_with_grace.sv
// hold press filter: top level with input register, state and result register
// a request is held in the input register, then its result is written to the result register
// throughput: one request per cycle while out_stall does not hold a result; the state update is combinational
// while a result waits on out_stall the input register takes one more request, then stalls
// reset: asynchronous active-low, clears state, loads register defaults
`include "assert_macros.svh"

module hold_press_filter_with_grace (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hpfg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hpfg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              metrics_valid,
	input  logic                              hold_request,
	input  logic [hpfg_pkg::TIME_W-1:0]       now_ms,
	input  logic                              tracking_mode,
	input  logic [hpfg_pkg::POS_W-1:0]        target_pos,
	input  logic [hpfg_pkg::POS_W-1:0]        bar_pos,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hold_out
);
	import hpfg_pkg::*;

	cfg_t   cfg;
	item_t  item_s1;
	logic   valid_s1;
	state_t state_q;
	state_t state_next;
	logic   hold_next;
	logic   out_valid_q;
	logic   hold_out_q;
	logic   in_fire;
	logic   adv_s1;

	hpfg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hpfg_step u_step (
		.item    (item_s1),
		.st      (state_q),
		.cfg     (cfg),
		.st_next (state_next),
		.hold    (hold_next)
	);

	// stage 1 moves on when the result register is free or being taken
	assign adv_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_fire = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.metrics_valid <= metrics_valid;
			item_s1.hold_request <= hold_request;
			item_s1.now_ms <= now_ms;
			item_s1.tracking_mode <= tracking_mode;
			item_s1.target_pos <= target_pos;
			item_s1.bar_pos <= bar_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (adv_s1) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hold_out_q <= hold_next;
		end
	end

	assign out_valid = out_valid_q;
	assign hold_out = hold_out_q;

	`ASSERT_IMPLIES(a_stall_needs_s1, clk, arst_n, in_stall, valid_s1 && out_valid_q, "input stalled without a pending request")
	`ASSERT_NEXT(a_out_tracks_state, clk, arst_n, adv_s1, hold_out == state_q.holding, "result differs from holding state")
	`ASSERT_NEXT(a_seen_time, clk, arst_n, adv_s1 && item_s1.metrics_valid, state_q.last_seen_at == $past(item_s1.now_ms), "last seen time not updated")

endmodule
